/* design/assert_macros.svh */
// Assertion macros shared by the shuffler RTL.
// Every macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property where the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rps_pkg.sv */
// Package for the random permutation shuffler: fixed widths, register
// indexes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package rps_pkg;

    localparam int WORD_W     = 64;   // random word width
    localparam int OUT_W      = 6;    // position / value field width
    localparam int SIZE_W     = 7;    // perm_size register width
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int S_TDATA_W  = 64;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 16;
    localparam int DIV_CNT_W  = $clog2(WORD_W + 1);

    localparam logic REG_PERM_SIZE = 1'b0;   // register index from paddr[2]
    localparam logic [SIZE_W-1:0] PERM_SIZE_RST = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SWAP_P,
        S_SWAP_J,
        S_READ0,
        S_LAST
    } t_state;

endpackage

/* design/random_permutation_shuffler.sv */
// Top level of the random permutation shuffler: stream in, stream out, APB
// register port. Depends on rps_pkg and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Backward Fisher-Yates shuffle. Each transfer on the slave stream carries
// one 64-bit random word; tuser bit 0 set starts a new permutation of
// perm_size elements (0 is taken as 1, sizes above MAX_ELEMENTS are clamped).
// A step item runs through the bit-serial restoring remainder unit (one bit of
// the word per cycle, then a hand-off), the two-port table read and the two
// swap writes before the block is ready again. The step at position 1 then
// reads entry 0 and sends it with tlast. A start item also loads the identity
// into the table, one entry per cycle on the single write port, overlapped with
// the remainder unit; a start with size 1 sends entry 0 at once. A full result
// register with m_axis_tready low stalls the swap and the last send. Non-start
// items while no walk is running are accepted and dropped.
module random_permutation_shuffler #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream; tdata: random_word[63:0]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rps_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: start_req[0]
    input  logic [rps_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // master stream; tdata: position[5:0], value[11:6], zero fill [15:12]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rps_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rps_pkg::PADDR_W-1:0]   paddr,
    input  logic [rps_pkg::PDATA_W-1:0]   pwdata,
    output logic [rps_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import rps_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int N_W   = IDX_W + 1;

    // registers
    t_state                r_state, n_state;
    logic                  r_active, n_active;
    logic                  r_one, n_one;
    logic [IDX_W-1:0]      r_pos, n_pos;
    logic [WORD_W-1:0]     r_word, n_word;
    logic [N_W-1:0]        r_rem, n_rem;
    logic [DIV_CNT_W-1:0]  r_div_left, n_div_left;
    logic [N_W-1:0]        r_fill_cnt, n_fill_cnt;
    logic [N_W-1:0]        r_fill_n, n_fill_n;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_W-1:0]      r_out_pos, n_out_pos;
    logic [OUT_W-1:0]      r_out_val, n_out_val;
    logic                  r_out_last, n_out_last;
    logic [SIZE_W-1:0]     r_perm_size;

    // table memory
    logic [IDX_W-1:0]      r_mem [MAX_ELEMENTS];
    logic [IDX_W-1:0]      r_rd_a, r_rd_b;
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr, mem_wdata;
    logic [IDX_W-1:0]      mem_raddr_a, mem_raddr_b;

    logic                  in_xfer, out_free, fill_done;
    logic [N_W-1:0]        size_n, divisor;
    logic [N_W:0]          trial, trial_diff;

    assign pready        = 1'b1;
    assign prdata        = PDATA_W'(r_perm_size);
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fill_done     = (r_fill_cnt == r_fill_n);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - 2 * OUT_W){1'b0}}, r_out_val, r_out_pos};
    assign m_axis_tlast  = r_out_last;

    // clamp the configured size to 1 .. MAX_ELEMENTS
    always_comb begin
        if (r_perm_size == '0) begin
            size_n = N_W'(1);
        end else if (32'(r_perm_size) > 32'(MAX_ELEMENTS)) begin
            size_n = N_W'(MAX_ELEMENTS);
        end else begin
            size_n = N_W'(r_perm_size);
        end
    end

    // restoring remainder step: shift in the next word bit, subtract if it fits
    assign divisor    = N_W'(r_pos) + N_W'(1);
    assign trial      = {r_rem, r_word[WORD_W-1]};
    assign trial_diff = trial - {1'b0, divisor};

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_one       = r_one;
        n_pos       = r_pos;
        n_word      = r_word;
        n_rem       = r_rem;
        n_div_left  = r_div_left;
        n_fill_cnt  = r_fill_cnt;
        n_fill_n    = r_fill_n;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_pos   = r_out_pos;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_rd_a;
        mem_re      = 1'b0;
        mem_raddr_a = r_pos;
        mem_raddr_b = r_rem[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_word     = s_axis_tdata;
                    n_rem      = '0;
                    n_div_left = DIV_CNT_W'(WORD_W);
                    n_fill_cnt = '0;
                    n_fill_n   = '0;
                    if (s_axis_tuser[0]) begin
                        if (size_n == N_W'(1)) begin
                            n_pos    = '0;
                            n_active = 1'b0;
                            n_one    = 1'b1;
                            n_state  = S_LAST;
                        end else begin
                            n_pos    = IDX_W'(size_n - N_W'(1));
                            n_active = 1'b1;
                            n_one    = 1'b0;
                            n_fill_n = size_n;
                            n_state  = S_DIV;
                        end
                    end else if (r_active) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // identity load runs alongside the remainder unit
                if (!fill_done) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_fill_cnt[IDX_W-1:0];
                    mem_wdata  = r_fill_cnt[IDX_W-1:0];
                    n_fill_cnt = r_fill_cnt + N_W'(1);
                end
                if (r_div_left != '0) begin
                    n_word     = {r_word[WORD_W-2:0], 1'b0};
                    n_rem      = trial_diff[N_W] ? trial[N_W-1:0] : trial_diff[N_W-1:0];
                    n_div_left = r_div_left - DIV_CNT_W'(1);
                end else if (fill_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_SWAP_P;
            end
            S_SWAP_P: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_pos;
                    mem_wdata   = r_rd_b;
                    n_out_valid = 1'b1;
                    n_out_pos   = OUT_W'(r_pos);
                    n_out_val   = OUT_W'(r_rd_b);
                    n_out_last  = 1'b0;
                    n_state     = S_SWAP_J;
                end
            end
            S_SWAP_J: begin
                mem_we    = 1'b1;
                mem_waddr = r_rem[IDX_W-1:0];
                mem_wdata = r_rd_a;
                if (r_pos == IDX_W'(1)) begin
                    n_pos    = '0;
                    n_active = 1'b0;
                    n_state  = S_READ0;
                end else begin
                    n_pos   = r_pos - IDX_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_READ0: begin
                mem_re      = 1'b1;
                mem_raddr_a = '0;
                n_state     = S_LAST;
            end
            S_LAST: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = '0;
                    n_out_val   = r_one ? '0 : OUT_W'(r_rd_a);
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_one       <= 1'b0;
            r_pos       <= '0;
            r_div_left  <= '0;
            r_fill_cnt  <= '0;
            r_fill_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_one       <= n_one;
            r_pos       <= n_pos;
            r_div_left  <= n_div_left;
            r_fill_cnt  <= n_fill_cnt;
            r_fill_n    <= n_fill_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_rem      <= n_rem;
        r_out_pos  <= n_out_pos;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_size <= PERM_SIZE_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PERM_SIZE)) begin
            r_perm_size <= pwdata[SIZE_W-1:0];
        end
    end

    // table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_a <= r_mem[mem_raddr_a];
            r_rd_b <= r_mem[mem_raddr_b];
        end
    end

    `ASSERT_ALWAYS(a_active_pos,
        (r_state != S_IDLE) || !r_active || (r_pos != '0), "active with position zero")
    `ASSERT_ALWAYS(a_rem_range,
        (r_state != S_READ) || (r_rem <= N_W'(r_pos)), "remainder above position")
    `ASSERT_ALWAYS(a_last_pos,
        !(m_axis_tvalid && m_axis_tlast) || (m_axis_tdata[OUT_W-1:0] == '0),
        "last not at position zero")
    `ASSERT_NEXT(a_div_exit, (r_state == S_DIV) && (n_state == S_READ),
        (r_fill_cnt == r_fill_n) && (r_div_left == '0),
        "table read before fill or remainder done")

endmodule

/* sim/tb_random_permutation_shuffler.sv */
// Self-checking bench for random_permutation_shuffler: directed table, then random
// shuffle phases at several sizes, results scored against the table or a local shuffle model.
// Depends on rps_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_random_permutation_shuffler;

    localparam int MAX_ELEM  = 64;
    localparam int SETTLE    = 80;      // margin after the last result before a register write
    localparam int N_RANDOM  = 1350;    // random items that advance a walk
    localparam int HOLD_AT   = 300;     // results seen before the long receiver hold
    localparam int HOLD_LEN  = 600;
    localparam logic [rps_pkg::PADDR_W-1:0] ADDR_PERM_SIZE = {rps_pkg::REG_PERM_SIZE, 2'b00};

    typedef struct packed {
        logic [5:0] pos;
        logic [5:0] val;
        logic       last;
    } t_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // ROW_CFG rows carry the new perm_size in word[6:0]
    typedef struct packed {
        t_row_kind  kind;
        logic [63:0] word;
        logic       start;
        logic       typed;     // 1: expected results below, 0: from the shuffle model
        logic [1:0] n_res;
        t_result    r0;
        t_result    r1;
    } t_row;

    localparam t_result NO_RES = '0;
    localparam logic [63:0] ONES = '1;
    localparam int N_DIRECTED = 23;

    localparam t_row DIRECTED [N_DIRECTED] = '{
        // reset state: idle drop, then a start at the reset size of 64
        '{ROW_ITEM, ONES, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, ONES, 1'b1, 1'b1, 2'd1, '{6'd63, 6'd63, 1'b0}, NO_RES},
        // size one, first start abandons the 64-entry walk
        '{ROW_CFG, 64'd1, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, 64'd0, 1'b1, 1'b1, 2'd1, '{6'd0, 6'd0, 1'b1}, NO_RES},
        '{ROW_ITEM, ONES, 1'b1, 1'b1, 2'd1, '{6'd0, 6'd0, 1'b1}, NO_RES},
        '{ROW_ITEM, 64'd5, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        // size two: swap or keep, both entries in one step
        '{ROW_CFG, 64'd2, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, 64'd0, 1'b1, 1'b1, 2'd2, '{6'd1, 6'd0, 1'b0}, '{6'd0, 6'd1, 1'b1}},
        '{ROW_ITEM, 64'd1, 1'b1, 1'b1, 2'd2, '{6'd1, 6'd1, 1'b0}, '{6'd0, 6'd0, 1'b1}},
        '{ROW_ITEM, ONES, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        // size zero acts as one
        '{ROW_CFG, 64'd0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 2'd1, '{6'd0, 6'd0, 1'b1}, NO_RES},
        // oversize clamps to 64; restart in the middle of a walk
        '{ROW_CFG, 64'd127, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, ONES, 1'b1, 1'b1, 2'd1, '{6'd63, 6'd63, 1'b0}, NO_RES},
        '{ROW_ITEM, 64'd0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, 64'd0, 1'b1, 1'b1, 2'd1, '{6'd63, 6'd0, 1'b0}, NO_RES},
        // size changes while a walk is running only matter at the next start
        '{ROW_CFG, 64'd3, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, 64'd5, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_CFG, 64'd64, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, ONES, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_CFG, 64'd65, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [rps_pkg::S_TDATA_W-1:0] s_axis_tdata;    // random_word[63:0]
    logic [rps_pkg::S_TUSER_W-1:0] s_axis_tuser;    // start_req[0]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [rps_pkg::M_TDATA_W-1:0] m_axis_tdata;    // position[5:0], value[11:6], zero [15:12]
    logic                          m_axis_tlast;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rps_pkg::PADDR_W-1:0]   paddr;
    logic [rps_pkg::PDATA_W-1:0]   pwdata;
    logic [rps_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // shuffle model state
    logic [5:0] perm_order [MAX_ELEM];
    int         walk_pos;
    bit         walking;
    logic [6:0] size_cfg;

    t_result pending_q [$];
    int      mismatch_count;
    int      results_checked;
    int      walk_items;
    int      burst_left;
    bit      hold_done;

    random_permutation_shuffler #(
        .MAX_ELEMENTS(MAX_ELEM)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

    // One Fisher-Yates step on the local table; returns the entries that become final.
    task automatic shuffle_step(input logic [63:0] word, input bit start, output int cnt,
                                output t_result r0, output t_result r1);
        int n;
        int i;
        int p;
        int j;
        logic [63:0] modulus;
        logic [5:0] tmp;
        cnt = 0;
        r0 = '0;
        r1 = '0;
        if (start) begin
            n = int'(size_cfg);
            if (n < 1) n = 1;
            if (n > MAX_ELEM) n = MAX_ELEM;
            for (i = 0; i < n; i++) perm_order[i] = i[5:0];
            if (n == 1) begin
                walk_pos = 0;
                walking = 1'b0;
                r0 = '{6'd0, perm_order[0], 1'b1};
                cnt = 1;
                return;
            end
            walk_pos = n - 1;
            walking = 1'b1;
        end else if (!walking) begin
            return;
        end
        p = walk_pos;
        modulus = 64'(p + 1);
        j = int'(word % modulus);
        tmp = perm_order[p];
        perm_order[p] = perm_order[j];
        perm_order[j] = tmp;
        r0 = '{p[5:0], perm_order[p], 1'b0};
        cnt = 1;
        if (p == 1) begin
            r1 = '{6'd0, perm_order[0], 1'b1};
            cnt = 2;
            walk_pos = 0;
            walking = 1'b0;
        end else begin
            walk_pos = p - 1;
        end
    endtask

    // Returns at the rising edge of the transfer; valid stays up for a back-to-back item.
    task automatic send_item(input logic [63:0] word, input bit start);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic feed_word(input logic [63:0] word, input bit start);
        int cnt;
        t_result r0;
        t_result r1;
        send_item(word, start);
        shuffle_step(word, start, cnt, r0, r1);
        if (cnt > 0) pending_q.push_back(r0);
        if (cnt > 1) pending_q.push_back(r1);
        if (cnt > 0) walk_items++;
    endtask

    // Stop sending and let every outstanding result drain.
    task automatic quiesce();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_perm_size(input logic [6:0] sz, input logic [24:0] junk);
        quiesce();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_PERM_SIZE;
        pwdata  <= {junk, sz};      // bits above the register are don't care
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        size_cfg = sz;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '1;
            1:       return '0;
            2, 3:    return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [6:0] pick_perm_size();
        case ($urandom_range(0, 19))
            0:       return 7'd0;
            1:       return 7'($urandom_range(65, 127));
            2, 3:    return 7'd64;
            4:       return 7'($urandom_range(17, 63));
            default: return 7'($urandom_range(1, 16));
        endcase
    endfunction

    // receiver: random stall stretches, one long hold to back up the block
    initial begin : rx_pattern
        int len;
        int mode;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && results_checked >= HOLD_AT) begin
                hold_done = 1'b1;
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
            end
            mode = $urandom_range(0, 2);
            len  = $urandom_range(1, 40);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected transfer pos %0d val %0d last %0b", $time,
                         m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata[5:0] !== want.pos) begin
                    $display("%0t: position expected %0d got %0d", $time, want.pos,
                             m_axis_tdata[5:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[11:6] !== want.val) begin
                    $display("%0t: value expected %0d got %0d", $time, want.val,
                             m_axis_tdata[11:6]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %0b got %0b", $time, want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int r;
        int cnt;
        int k;
        int n_eff;
        int n_perm;
        logic [6:0] sz;
        t_result r0;
        t_result r1;
        t_row row;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        size_cfg       = rps_pkg::PERM_SIZE_RST;
        walk_pos       = 0;
        walking        = 1'b0;
        mismatch_count = 0;
        results_checked = 0;
        walk_items     = 0;
        burst_left     = 0;
        hold_done      = 1'b0;
        for (k = 0; k < MAX_ELEM; k++) perm_order[k] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                set_perm_size(row.word[6:0], '0);
            end else begin
                send_item(row.word, row.start);
                shuffle_step(row.word, row.start, cnt, r0, r1);
                if (row.typed) begin
                    cnt = int'(row.n_res);
                    r0 = row.r0;
                    r1 = row.r1;
                end
                if (cnt > 0) pending_q.push_back(r0);
                if (cnt > 1) pending_q.push_back(r1);
            end
        end

        // random phases: mostly complete walks, some stray and abandoned ones
        walk_items = 0;
        while (walk_items < N_RANDOM) begin
            sz = pick_perm_size();
            set_perm_size(sz, 25'($urandom));
            n_eff = (sz < 1) ? 1 : ((sz > MAX_ELEM) ? MAX_ELEM : int'(sz));
            n_perm = (n_eff > 16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
            repeat (n_perm) begin
                if ($urandom_range(0, 11) == 0) feed_word(rand_word(), 1'b0);
                feed_word(rand_word(), 1'b1);
                for (k = 1; k < n_eff; k++) begin
                    if ($urandom_range(0, 39) == 0) break;
                    feed_word(rand_word(), 1'b0);
                end
            end
        end

        quiesce();
        if (pending_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
